### src/lcdws_pkg.sv
// ----------------------------------------------------------------------------
// lcdws_pkg
// Shared types and constants of the character-LCD write sequencer: request
// codes, run kinds, the run descriptor and the fixed LCD command bytes.
// ----------------------------------------------------------------------------
package lcdws_pkg;

  // Request codes on req_type.
  localparam logic [2:0] REQ_CMD   = 3'd0;
  localparam logic [2:0] REQ_CHAR  = 3'd1;
  localparam logic [2:0] REQ_POS   = 3'd2;
  localparam logic [2:0] REQ_NUM   = 3'd3;
  localparam logic [2:0] REQ_INIT  = 3'd4;
  localparam logic [2:0] REQ_CLEAR = 3'd5;

  // LCD command bytes.
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_HOME     = 8'h02;
  localparam logic [7:0] CMD_ENTRY    = 8'h06;
  localparam logic [7:0] CMD_DISP_CUR = 8'h0E;
  localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
  localparam logic [7:0] CMD_WAKE_A   = 8'h33;
  localparam logic [7:0] CMD_WAKE_B   = 8'h32;
  localparam logic [7:0] CMD_FUNC4    = 8'h28;
  localparam logic [7:0] CMD_FUNC8    = 8'h38;
  localparam logic [7:0] LINE1_BASE   = 8'h80;
  localparam logic [7:0] LINE2_BASE   = 8'hC0;
  localparam logic [7:0] ASCII_ZERO   = 8'd48;

  // Timing values in microseconds.
  localparam logic [10:0] HOLD_LONG  = 11'd2000;
  localparam logic [10:0] HOLD_SHORT = 11'd100;
  localparam logic [15:0] INIT_LEAD  = 16'd50000;

  // Largest digit count a number can have, and strobe cap per request.
  localparam int DIG_SLOTS   = 5;
  localparam int MAX_STROBES = 16;

  // Kind of run the back end carries out.
  typedef enum logic [2:0] {
    OP_CMD,
    OP_CHAR,
    OP_NUM,
    OP_INIT4,
    OP_INIT8,
    OP_CLEAR
  } op_t;

  // One classified request, handed from the front end to the back end.
  typedef struct packed {
    op_t                        op;
    logic [7:0]                 value;   // command or character byte
    logic [DIG_SLOTS-1:0][3:0]  digits;  // least significant digit in slot 0
    logic [2:0]                 ndig;    // digit count of a number
  } desc_t;

endpackage

### src/char_lcd_write_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer
// Turns character-LCD requests into runs of enable-strobe words.
// ----------------------------------------------------------------------------
// Usage: requests enter on the in_valid/in_ready channel, one word each
// (req_type with byte_value, row, column or number). Each request yields a
// run of strobe words on the out_valid/out_ready channel; the final word of
// a run has last set. Requests that produce no strobes are absorbed.
// Path: an accepted request goes through the front-end descriptor register,
// a queue slot and the output register; a number is converted digit by digit
// first. Throughput: one strobe word per cycle while out_ready is high and
// a run waits at the queue head; a run has from 1 to 16 strobes, and the
// output register of the back end sets the rate. Digit conversion in the front
// end overlaps with the run before it through a two-entry queue.
// bus_mode is set through the APB port at address 0 and should only be
// written while the block is idle. Reset selects the four-bit bus and empties
// the queue. When the receiver stalls, the output word holds and the queue
// and front end keep taking requests until they fill.
// ----------------------------------------------------------------------------
module char_lcd_write_sequencer #(
  parameter int MAX_DIGITS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [7:0]  byte_value,
  input  logic [1:0]  row,
  input  logic [5:0]  column,
  input  logic [15:0] number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        reg_select,
  output logic [7:0]  bus_value,
  output logic [15:0] lead_us,
  output logic [10:0] hold_us,
  output logic        last
);
  import lcdws_pkg::*;

  localparam logic REG_BUS_MODE = 1'b0;

  logic  bus_mode;
  logic  push;
  desc_t push_desc;
  logic  q_full;
  logic  head_valid;
  desc_t head_desc;
  logic  pop;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BUS_MODE) ? {31'd0, bus_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_mode <= 1'b1;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_BUS_MODE) begin
      bus_mode <= pwdata[0];
    end
  end

  lcdws_front #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .bus_mode   (bus_mode),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .byte_value (byte_value),
    .row        (row),
    .column     (column),
    .number     (number),
    .push       (push),
    .push_desc  (push_desc),
    .q_full     (q_full)
  );

  lcdws_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .full       (q_full),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .pop        (pop)
  );

  lcdws_back u_back (
    .clk        (clk),
    .rst        (rst),
    .bus_mode   (bus_mode),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .reg_select (reg_select),
    .bus_value  (bus_value),
    .lead_us    (lead_us),
    .hold_us    (hold_us),
    .last       (last)
  );

endmodule

### src/lcdws_front.sv
// ----------------------------------------------------------------------------
// lcdws_front
// Accepts requests, drops the ones that produce nothing and too-long numbers,
// resolves cursor addresses, turns numbers into decimal digits one per cycle.
// ----------------------------------------------------------------------------
module lcdws_front #(
  parameter int MAX_DIGITS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              bus_mode,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        req_type,
  input  logic [7:0]        byte_value,
  input  logic [1:0]        row,
  input  logic [5:0]        column,
  input  logic [15:0]       number,
  output logic              push,
  output lcdws_pkg::desc_t  push_desc,
  input  logic              q_full
);
  import lcdws_pkg::*;

  localparam int unsigned LIMIT = 10 ** MAX_DIGITS;

  desc_t       desc;
  logic        desc_valid;
  logic        converting;
  logic [15:0] work;

  desc_t       cls_desc;
  logic        cls_keep;
  logic        cls_num;
  logic        accept;
  logic [31:0] prod;
  logic [12:0] quot;
  logic [15:0] quot_x10;
  logic [3:0]  rem;

  assign push      = desc_valid && !converting && !q_full;
  assign in_ready  = !desc_valid || push;
  assign accept    = in_valid && in_ready;
  assign push_desc = desc;

  // Classify the incoming word.
  always_comb begin
    cls_desc        = '0;
    cls_desc.op     = OP_CMD;
    cls_desc.value  = byte_value;
    cls_keep        = 1'b1;
    cls_num         = 1'b0;
    case (req_type)
      REQ_CMD: begin
        cls_desc.op = OP_CMD;
      end
      REQ_CHAR: begin
        cls_desc.op = OP_CHAR;
      end
      REQ_POS: begin
        cls_desc.op = OP_CMD;
        if (row == 2'd1) begin
          cls_desc.value = LINE1_BASE + {2'b00, column} + 8'hFF;
        end else if (row == 2'd2) begin
          cls_desc.value = LINE2_BASE + {2'b00, column} + 8'hFF;
        end else begin
          cls_keep = 1'b0;
        end
      end
      REQ_NUM: begin
        cls_desc.op = OP_NUM;
        cls_num     = 1'b1;
        cls_keep    = ({16'd0, number} < LIMIT[31:0]);
      end
      REQ_INIT: begin
        cls_desc.op = bus_mode ? OP_INIT4 : OP_INIT8;
      end
      REQ_CLEAR: begin
        cls_desc.op = OP_CLEAR;
      end
      default: begin
        cls_keep = 1'b0;
      end
    endcase
  end

  // Divide by ten with a reciprocal; exact for every 16-bit value.
  assign prod     = work * 32'd52429;
  assign quot     = prod[31:19];
  assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign rem      = 4'(work - quot_x10);

  // Descriptor register and digit extraction.
  always_ff @(posedge clk) begin
    if (rst) begin
      desc_valid <= 1'b0;
      converting <= 1'b0;
    end else begin
      if (accept) begin
        desc_valid <= cls_keep;
        converting <= cls_keep && cls_num;
        desc       <= cls_desc;
        work       <= number;
      end else if (push) begin
        desc_valid <= 1'b0;
      end else if (converting) begin
        desc.digits[desc.ndig] <= rem;
        desc.ndig              <= desc.ndig + 3'd1;
        work                   <= {3'b000, quot};
        if (quot == 13'd0) begin
          converting <= 1'b0;
        end
      end
    end
  end

  // A word being converted blocks the input.
  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    converting |-> !in_ready)
    else $error("front accepted a word while converting a number");

  // A number leaves with at least one digit.
  a_num_digits: assert property (@(posedge clk) disable iff (rst)
    (push && desc.op == OP_NUM) |-> (desc.ndig != 3'd0))
    else $error("number descriptor pushed without digits");

endmodule

### src/lcdws_queue.sv
// ----------------------------------------------------------------------------
// lcdws_queue
// Two-entry queue of run descriptors between the front and back ends.
// ----------------------------------------------------------------------------
module lcdws_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lcdws_pkg::desc_t  push_desc,
  output logic              full,
  output logic              head_valid,
  output lcdws_pkg::desc_t  head_desc,
  input  logic              pop
);
  import lcdws_pkg::*;

  desc_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_desc  = slots[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_desc;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### src/lcdws_back.sv
// ----------------------------------------------------------------------------
// lcdws_back
// Walks the bytes of the run at the queue head, splits them into nibbles on a
// four-bit bus and issues a strobe word per cycle to the output if not stalled.
// ----------------------------------------------------------------------------
module lcdws_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              bus_mode,
  input  logic              head_valid,
  input  lcdws_pkg::desc_t  head_desc,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              reg_select,
  output logic [7:0]        bus_value,
  output logic [15:0]       lead_us,
  output logic [10:0]       hold_us,
  output logic              last
);
  import lcdws_pkg::*;

  // Register-select level and byte at a position in a run.
  function automatic logic [8:0] byte_at(input desc_t d, input logic [3:0] idx);
    logic [2:0] slot;
    logic [8:0] res;
    slot = d.ndig - 3'd1 - idx[3:1];
    res  = {1'b0, CMD_ENTRY};
    case (d.op)
      OP_CMD:  res = {1'b0, d.value};
      OP_CHAR: res = idx[0] ? {1'b0, CMD_ENTRY} : {1'b1, d.value};
      OP_NUM:  res = idx[0] ? {1'b0, CMD_ENTRY}
                            : {1'b1, ASCII_ZERO + {4'd0, d.digits[slot]}};
      OP_INIT4: begin
        case (idx)
          4'd0:    res = {1'b0, CMD_CLEAR};
          4'd1:    res = {1'b0, CMD_WAKE_A};
          4'd2:    res = {1'b0, CMD_WAKE_B};
          4'd3:    res = {1'b0, CMD_FUNC4};
          default: res = {1'b0, CMD_DISP_ON};
        endcase
      end
      OP_INIT8: begin
        case (idx)
          4'd0:    res = {1'b0, CMD_FUNC8};
          4'd1:    res = {1'b0, CMD_CLEAR};
          default: res = {1'b0, CMD_DISP_CUR};
        endcase
      end
      OP_CLEAR: res = idx[0] ? {1'b0, CMD_DISP_CUR} : {1'b0, CMD_CLEAR};
      default:  res = {1'b0, CMD_ENTRY};
    endcase
    return res;
  endfunction

  // Number of bytes in a run.
  function automatic logic [3:0] byte_count(input desc_t d);
    logic [3:0] n;
    case (d.op)
      OP_CMD:   n = 4'd1;
      OP_CHAR:  n = 4'd2;
      OP_NUM:   n = {d.ndig, 1'b0};
      OP_INIT4: n = 4'd5;
      OP_INIT8: n = 4'd3;
      OP_CLEAR: n = 4'd2;
      default:  n = 4'd1;
    endcase
    return n;
  endfunction

  logic [3:0] b_idx;
  logic       nib;
  logic [3:0] scount;

  logic       cur_rs;
  logic [7:0] cur_byte;
  logic [3:0] nbytes;
  logic       byte_done;
  logic       strobe_last;
  logic       advance;
  logic [7:0] bus_next;
  logic [10:0] hold_next;
  logic [15:0] lead_next;

  // Strobe generation for the current position.
  always_comb begin
    {cur_rs, cur_byte} = byte_at(head_desc, b_idx);
    nbytes      = byte_count(head_desc);
    byte_done   = !bus_mode || nib;
    strobe_last = ((b_idx == nbytes - 4'd1) && byte_done) ||
                  (scount == 4'(MAX_STROBES - 1));
    advance     = head_valid && (!out_valid || out_ready);
    pop         = advance && strobe_last;
    if (!bus_mode) begin
      bus_next = cur_byte;
    end else if (nib) begin
      bus_next = {cur_byte[3:0], 4'h0};
    end else begin
      bus_next = {cur_byte[7:4], 4'h0};
    end
    hold_next = (!cur_rs && (cur_byte == CMD_CLEAR || cur_byte == CMD_HOME)) ?
                HOLD_LONG : HOLD_SHORT;
    lead_next = (head_desc.op == OP_INIT4 && b_idx == 4'd0 && !nib) ?
                INIT_LEAD : 16'd0;
  end

  // Position counters and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      b_idx     <= 4'd0;
      nib       <= 1'b0;
      scount    <= 4'd0;
    end else begin
      if (advance) begin
        out_valid  <= 1'b1;
        reg_select <= cur_rs;
        bus_value  <= bus_next;
        lead_us    <= lead_next;
        hold_us    <= hold_next;
        last       <= strobe_last;
        if (strobe_last) begin
          b_idx  <= 4'd0;
          nib    <= 1'b0;
          scount <= 4'd0;
        end else begin
          scount <= scount + 4'd1;
          if (byte_done) begin
            b_idx <= b_idx + 4'd1;
            nib   <= 1'b0;
          end else begin
            nib <= 1'b1;
          end
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The byte position stays inside the run at the head.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (b_idx < nbytes))
    else $error("byte position beyond the end of the run");

  // A run that has not finished keeps its head entry.
  a_head_kept: assert property (@(posedge clk) disable iff (rst)
    (advance && !strobe_last) |=> head_valid)
    else $error("queue head vanished in the middle of a run");

endmodule
